// ===== rtl/core/gpt_pkg.sv =====
// Shared types, constants and constant tables of the gray-level point transform.
// Depends on nothing; every other file of the block imports it.
package gpt_pkg;

  localparam int PIX_W   = 8;
  localparam int PIX_N   = 256;
  localparam int FRAC_W  = 16;
  localparam int LUT_W   = 19;
  localparam int GAIN_W  = 16;
  localparam int GAMMA_W = 12;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int EG_W    = 31;
  localparam int LG_W    = 35;
  localparam int NUM_W   = 27;
  localparam int DEN_W   = 19;
  localparam int M_W     = 18;
  localparam int IP_W    = 8;

  localparam logic [PIX_W-1:0]  PIX_MAX = 8'd255;
  localparam logic [31:0]       LN2Q32  = 32'hB172_17F8;

  typedef enum logic [1:0] {
    MODE_NEG     = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_LOG     = 2'd2,
    MODE_POW     = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_MIN   = 3'd1,
    REG_MAX   = 3'd2,
    REG_GAIN  = 3'd3,
    REG_GAMMA = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_FIXED = 2'd0,
    SEL_DIV   = 2'd1,
    SEL_POW   = 2'd2
  } sel_t;

  typedef struct packed {
    sel_t             sel;
    logic [PIX_W-1:0] fixed;
  } side_t;

  typedef logic [PIX_N-1:0][LUT_W-1:0] lut_t;

  function automatic logic [63:0] log2_fx(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] fr;
    int          n;
    n = 0;
    for (int i = 0; i < 40; i++) begin
      if ((x >> (i + 1)) != 64'd0) n = i + 1;
    end
    y  = x << (30 - n);
    fr = 64'd0;
    for (int k = 0; k < FRAC_W; k++) begin
      y  = (y * y) >> 30;
      fr = fr << 1;
      if (y >= 64'h8000_0000) begin
        y     = y >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(n) << FRAC_W) | fr;
  endfunction

  function automatic logic [63:0] ln_fx(input logic [63:0] x);
    return (log2_fx(x) * 64'(LN2Q32) + 64'h8000_0000) >> 32;
  endfunction

  function automatic lut_t build_ln_lut();
    lut_t t;
    for (int i = 0; i < PIX_N; i++) t[i] = LUT_W'(ln_fx(64'(i + 1)));
    return t;
  endfunction

  function automatic lut_t build_l2_lut();
    lut_t t;
    for (int i = 0; i < PIX_N; i++) t[i] = LUT_W'(log2_fx(64'(i)));
    return t;
  endfunction

  localparam lut_t LN_LUT = build_ln_lut();
  localparam lut_t L2_LUT = build_l2_lut();

endpackage

// ===== rtl/core/gpt_pixel_if.sv =====
// Pixel stream interfaces: input and result channels with valid/ready transfer.
// Depends on gpt_pkg for the pixel width.
interface gpt_pix_in_if;
  import gpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gpt_pix_out_if;
  import gpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== rtl/core/gpt_div.sv =====
// Pipelined restoring divider, one quotient bit a stage, rounded and clamped to a pixel.
// Ten register stages under a shared enable. Depends on gpt_pkg.
module gpt_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gpt_pkg::NUM_W-1:0]  num_i,
  input  logic [gpt_pkg::DEN_W-1:0]  den_i,
  output logic [gpt_pkg::PIX_W-1:0]  q_o
);
  import gpt_pkg::*;

  localparam int NB = PIX_W;

  logic [NUM_W-1:0] rem_r [0:NB];
  logic [DEN_W-1:0] den_r [0:NB];
  logic [NB-1:0]    q_r   [0:NB];
  logic             ovf_r [0:NB];
  logic [PIX_W-1:0] q_out_r;

  logic [NUM_W-1:0] sub_w [0:NB-1];
  logic             ge_w  [0:NB-1];
  logic             ovf_w;
  logic [NUM_W:0]   twice_w;
  logic             up_w;
  logic [NB:0]      qs_w;

  always_comb begin
    ovf_w = num_i >= (NUM_W'(den_i) << NB);
    for (int j = 0; j < NB; j++) begin
      sub_w[j] = NUM_W'(den_r[j]) << (NB - 1 - j);
      ge_w[j]  = rem_r[j] >= sub_w[j];
    end
    twice_w = {rem_r[NB], 1'b0};
    up_w    = (twice_w > (NUM_W + 1)'(den_r[NB])) ||
              ((twice_w == (NUM_W + 1)'(den_r[NB])) && q_r[NB][0]);
    qs_w    = {1'b0, q_r[NB]} + (NB + 1)'(up_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_w;
      for (int j = 0; j < NB; j++) begin
        rem_r[j+1] <= ge_w[j] ? rem_r[j] - sub_w[j] : rem_r[j];
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= {q_r[j][NB-2:0], ge_w[j]};
        ovf_r[j+1] <= ovf_r[j];
      end
      q_out_r <= (ovf_r[NB] || qs_w[NB]) ? PIX_MAX : qs_w[NB-1:0];
    end
  end

  assign q_o = q_out_r;

endmodule

// ===== rtl/core/gpt_exp2.sv =====
// Pipelined exponent split and 2^f evaluation by a truncated Taylor series in Q.32.
// Twenty-five register stages under a shared enable. Depends on gpt_pkg.
module gpt_exp2 (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gpt_pkg::EG_W-1:0]  eg_i,
  output logic [gpt_pkg::M_W-1:0]   m_o,
  output logic [gpt_pkg::IP_W-1:0]  ip_o
);
  import gpt_pkg::*;

  localparam int NT   = 11;
  localparam int SUMW = 34;
  localparam int BP_W = 68;
  localparam logic [SUMW-1:0] ONE_Q32 = SUMW'(64'h1_0000_0000);

  logic [FRAC_W-1:0] f0_r;
  logic [IP_W-1:0]   ip0_r;
  logic [31:0]       x1_r;
  logic [IP_W-1:0]   ip1_r;

  logic [31:0]       va_r [0:NT-1];
  logic [31:0]       xa_r [0:NT-1];
  logic [SUMW-1:0]   sa_r [0:NT-1];
  logic [IP_W-1:0]   ia_r [0:NT-1];
  logic [31:0]       tb_r [0:NT-1];
  logic [31:0]       xb_r [0:NT-1];
  logic [SUMW-1:0]   sb_r [0:NT-1];
  logic [IP_W-1:0]   ib_r [0:NT-1];
  logic [M_W-1:0]    m_r;
  logic [IP_W-1:0]   ip_r;

  logic [31:0]       ew_w;
  logic [47:0]       xp_w;
  logic [31:0]       tin_w [0:NT-1];
  logic [31:0]       xin_w [0:NT-1];
  logic [SUMW-1:0]   sin_w [0:NT-1];
  logic [IP_W-1:0]   iin_w [0:NT-1];
  logic [63:0]       ap_w  [0:NT-1];
  logic [31:0]       tn_w  [0:NT-1];
  logic [SUMW-1:0]   fin_w;

  always_comb begin
    ew_w = 32'(eg_i) + 32'd128;
    xp_w = 48'(f0_r) * 48'(LN2Q32);
    for (int j = 0; j < NT; j++) begin
      if (j == 0) begin
        tin_w[j] = x1_r;
        xin_w[j] = x1_r;
        sin_w[j] = ONE_Q32;
        iin_w[j] = ip1_r;
      end else begin
        tin_w[j] = tb_r[j-1];
        xin_w[j] = xb_r[j-1];
        sin_w[j] = sb_r[j-1];
        iin_w[j] = ib_r[j-1];
      end
      ap_w[j] = 64'(tin_w[j]) * 64'(xin_w[j]);
    end
    fin_w = sb_r[NT-1] + SUMW'(tb_r[NT-1]) + SUMW'(32'h8000);
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int K = j + 2;
    localparam int L = $clog2(K);
    localparam int S = 32 + L;
    localparam logic [63:0] MK = ((64'd1 << S) + 64'(K) - 64'd1) / 64'(K);
    logic [BP_W-1:0] bp_w;
    assign bp_w     = BP_W'(va_r[j]) * BP_W'(MK[32:0]);
    assign tn_w[j]  = bp_w[S+31:S];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r  <= ew_w[23:8];
      ip0_r <= ew_w[31:24];
      x1_r  <= xp_w[47:16];
      ip1_r <= ip0_r;
      for (int j = 0; j < NT; j++) begin
        va_r[j] <= ap_w[j][63:32];
        xa_r[j] <= xin_w[j];
        sa_r[j] <= sin_w[j] + SUMW'(tin_w[j]);
        ia_r[j] <= iin_w[j];
        tb_r[j] <= tn_w[j];
        xb_r[j] <= xa_r[j];
        sb_r[j] <= sa_r[j];
        ib_r[j] <= ia_r[j];
      end
      m_r  <= fin_w[SUMW-1:FRAC_W];
      ip_r <= ib_r[NT-1];
    end
  end

  assign m_o  = m_r;
  assign ip_o = ip_r;

endmodule

// ===== rtl/core/gray_point_transform_unit.sv =====
// Top level of the gray-level point transform: registers, table stages, result select.
// Depends on gpt_pkg, gpt_pixel_if, gpt_div and gpt_exp2.
//
// Usage:
//   in_pix carries one 8-bit pixel per transfer; out_pix returns one transformed
//   pixel per input, in order. The cfg port writes transform_mode, min_level,
//   max_level, gain_q8_8 and gamma_q4_8 at indexes 0 to 4 on any edge with
//   cfg_we high and rst_n high; other indexes are ignored. Write only while no
//   pixel is in flight.
//   The pipeline depth is set by the 2^f series in gpt_exp2 (two stages per
//   term); negative, stretch and log results travel down a matching delay line.
//   Throughput is one pixel per cycle while out_pix does not stall.
//   Reset clears all valid bits and loads the register defaults: negative mode,
//   min 0, max 255, gain 0, gamma 1.0.
//   When out_pix stalls with a result waiting, the pipeline keeps advancing
//   while its last stage is empty and holds once that stage is full; in_pix.ready
//   then drops and nothing is lost or repeated.
module gray_point_transform_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [gpt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gpt_pkg::CFG_W-1:0]  cfg_wdata,
  gpt_pix_in_if.sink                 in_pix,
  gpt_pix_out_if.source              out_pix
);
  import gpt_pkg::*;

  localparam int NST    = 30;
  localparam int LAST   = NST - 1;
  localparam int SIDE_N = 26;
  localparam int DQ_N   = 16;
  localparam int PROD_W = GAIN_W + M_W;
  localparam int SH_W   = PROD_W + 16;
  localparam int BIG_IP = PIX_W + 9;

  mode_t              mode_r;
  logic [PIX_W-1:0]   min_r;
  logic [PIX_W-1:0]   max_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [GAMMA_W-1:0] gamma_r;
  logic [LUT_W-1:0]   lm_r;

  logic [NST-1:0]     v_r;
  logic [PIX_W-1:0]   p0_r;
  logic [PIX_W-1:0]   p1_r;
  logic [LUT_W-1:0]   lp1_r;
  logic [LUT_W-1:0]   l21_r;
  logic [PIX_W-1:0]   p2_r;
  logic [EG_W-1:0]    eg2_r;
  logic [LG_W-1:0]    lg2_r;
  logic [NUM_W-1:0]   num2_r;
  logic [DEN_W-1:0]   den2_r;
  side_t              side_r [0:SIDE_N-1];
  logic [PIX_W-1:0]   dq_r   [0:DQ_N-1];
  logic [PROD_W-1:0]  prod28_r;
  logic [IP_W-1:0]    ip28_r;
  logic [PIX_W-1:0]   res29_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_data_r;

  logic               en;
  logic               out_load;
  logic [PIX_W-1:0]   diff_w;
  logic [PIX_W-1:0]   span_w;
  logic [NUM_W-1:0]   num_nxt;
  logic [DEN_W-1:0]   den_nxt;
  logic [10:0]        lgq_w;
  logic               lgup_w;
  logic [11:0]        lgs_w;
  logic [PIX_W-1:0]   lgpix_w;
  side_t              side_nxt;
  logic [PIX_W-1:0]   divq_w;
  logic [M_W-1:0]     m_w;
  logic [IP_W-1:0]    ip_w;
  logic [GAIN_W-1:0]  cval_w;
  logic [SH_W-1:0]    sh_w;
  logic               powup_w;
  logic [SH_W-24:0]   pows_w;
  logic [PIX_W-1:0]   powpix_w;
  logic [PIX_W-1:0]   res_nxt;

  assign en           = !v_r[LAST] || !out_valid_r || out_pix.ready;
  assign out_load     = v_r[LAST] && (!out_valid_r || out_pix.ready);
  assign in_pix.ready = en;
  assign out_pix.valid     = out_valid_r;
  assign out_pix.pixel_out = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NEG;
      min_r   <= '0;
      max_r   <= PIX_MAX;
      gain_r  <= '0;
      gamma_r <= GAMMA_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= mode_t'(cfg_wdata[1:0]);
        REG_MIN:   min_r   <= cfg_wdata[PIX_W-1:0];
        REG_MAX:   max_r   <= cfg_wdata[PIX_W-1:0];
        REG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_GAMMA: gamma_r <= cfg_wdata[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lm_r <= LN_LUT[max_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_pix.valid};
    end
  end

  always_comb begin
    diff_w = p1_r - min_r;
    span_w = max_r - min_r;
    if (mode_r == MODE_STRETCH) begin
      num_nxt = (NUM_W'(diff_w) << 8) - NUM_W'(diff_w);
      den_nxt = DEN_W'(span_w);
    end else begin
      num_nxt = (NUM_W'(lp1_r) << 8) - NUM_W'(lp1_r);
      den_nxt = lm_r;
    end
  end

  always_comb begin
    lgq_w   = lg2_r[LG_W-1:24];
    lgup_w  = (lg2_r[23:0] > 24'h80_0000) || ((lg2_r[23:0] == 24'h80_0000) && lgq_w[0]);
    lgs_w   = {1'b0, lgq_w} + 12'(lgup_w);
    lgpix_w = (lgs_w[11:8] != 4'd0) ? PIX_MAX : lgs_w[7:0];
    side_nxt.sel   = SEL_FIXED;
    side_nxt.fixed = '0;
    unique case (mode_r)
      MODE_NEG: begin
        side_nxt.fixed = PIX_MAX - p2_r;
      end
      MODE_STRETCH: begin
        if (!((max_r <= min_r) || (p2_r < min_r))) side_nxt.sel = SEL_DIV;
      end
      MODE_LOG: begin
        if (gain_r != '0) begin
          side_nxt.fixed = lgpix_w;
        end else if (lm_r == '0) begin
          side_nxt.fixed = (p2_r == '0) ? '0 : PIX_MAX;
        end else begin
          side_nxt.sel = SEL_DIV;
        end
      end
      MODE_POW: begin
        if (!((p2_r == '0) && (gamma_r != '0))) side_nxt.sel = SEL_POW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= in_pix.pixel_in;
      p1_r   <= p0_r;
      lp1_r  <= LN_LUT[p0_r];
      l21_r  <= L2_LUT[p0_r];
      p2_r   <= p1_r;
      eg2_r  <= EG_W'(gamma_r) * EG_W'(l21_r);
      lg2_r  <= LG_W'(gain_r) * LG_W'(lp1_r);
      num2_r <= num_nxt;
      den2_r <= den_nxt;
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_N; i++) side_r[i] <= side_r[i-1];
      dq_r[0] <= divq_w;
      for (int i = 1; i < DQ_N; i++) dq_r[i] <= dq_r[i-1];
      prod28_r <= PROD_W'(cval_w) * PROD_W'(m_w);
      ip28_r   <= ip_w;
      res29_r  <= res_nxt;
    end
  end

  gpt_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num2_r),
    .den_i (den2_r),
    .q_o   (divq_w)
  );

  gpt_exp2 u_exp2 (
    .clk  (clk),
    .en   (en),
    .eg_i (eg2_r),
    .m_o  (m_w),
    .ip_o (ip_w)
  );

  always_comb begin
    cval_w   = (gain_r == '0) ? GAIN_W'(256) : gain_r;
    sh_w     = SH_W'(prod28_r) << ip28_r[4:0];
    powup_w  = (sh_w[23:0] > 24'h80_0000) || ((sh_w[23:0] == 24'h80_0000) && sh_w[24]);
    pows_w   = {1'b0, sh_w[SH_W-1:24]} + (SH_W - 23)'(powup_w);
    powpix_w = ((ip28_r >= IP_W'(BIG_IP)) || (pows_w[SH_W-24:8] != '0)) ?
               PIX_MAX : pows_w[7:0];
    unique case (side_r[SIDE_N-1].sel)
      SEL_DIV: res_nxt = dq_r[DQ_N-1];
      SEL_POW: res_nxt = powpix_w;
      default: res_nxt = side_r[SIDE_N-1].fixed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res29_r;
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0) && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && out_valid_r && !out_pix.ready) |=> (v_r[LAST] && out_valid_r))
    else $error("item lost during output stall");

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && in_pix.ready) |=> out_valid_r)
    else $error("last stage advanced without reaching the output register");

endmodule
